// ===== hdl/awc_pkg.sv =====
// Shared types, codes and constants of the activity window controller.
package awc_pkg;

  localparam int TIME_BITS = 20;
  localparam int HOOK_BITS = 4;
  localparam int CFG_IDX_BITS = 3;
  localparam int IN_DATA_BITS = 8;
  localparam int OUT_DATA_BITS = 16;

  localparam logic [HOOK_BITS-1:0] MAX_HOOKS = HOOK_BITS'(8);

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [HOOK_BITS-1:0] hooks_t;

  // Mode codes as they appear on the result channel.
  typedef enum logic [1:0] {
    MODE_SLEEP = 2'd0,
    MODE_UI    = 2'd1,
    MODE_BG    = 2'd2,
    MODE_GRACE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_IDLE   = 3'd2,
    OP_CANCEL = 3'd3,
    OP_SLEEP  = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_UI_WINDOW = 3'd0,
    CFG_BG_WINDOW = 3'd1,
    CFG_GRACE     = 3'd2,
    CFG_DEBOUNCE  = 3'd3,
    CFG_HOOKS     = 3'd4,
    CFG_UI_MODE   = 3'd5
  } cfg_idx_t;

  // Result beat, last field in the lowest bits.
  typedef struct packed {
    logic [2:0] pad;
    logic       rejected;
    logic       flush_user_queue;
    logic       cooperative_abort;
    logic       mandatory_abort;
    logic       drain_pending;
    hooks_t     hooks_to_run;
    logic       pool_running;
    logic       led_on;
    mode_t      mode;
  } result_t;

  // A length of zero is loaded as one tick.
  function automatic time_t load_len(input time_t v);
    return (v == '0) ? time_t'(1) : v;
  endfunction

endpackage

// ===== hdl/activity_window_controller.sv =====
// Top level of the activity window controller: event decoder, counters and result register.
//
//  Channel | Direction | Beat contents (lowest bits first)
//  in_     | slave     | tdata[2:0] opcode, tdata[3] pool_busy, tdata[7:4] zero
//  out_    | master    | tdata[1:0] mode, [2] led_on, [3] pool_running, [7:4] hooks_to_run,
//          |           | [8] drain_pending, [9] mandatory_abort, [10] cooperative_abort,
//          |           | [11] flush_user_queue, [12] rejected, [15:13] zero
//  cfg_    | slave     | cfg_index register number, cfg_data[19:0] value
//
// Every event beat yields exactly one result beat, registered in the cycle after it is accepted.
// A new beat is taken in every cycle in which the result register is empty or being
// emptied, so the block sustains one beat per clock; the only path that sets this is
// the combinational update of the mode and the three 20-bit counters.
// The synchronous active-low reset puts the block asleep with all counters stopped and
// loads the default lengths; configuration writes are always taken outside reset.
// A stall on the result side holds the result register and, through in_tready, the input.
module activity_window_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  // Event beats: [2:0] opcode, [3] pool_busy, [7:4] zero.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [awc_pkg::IN_DATA_BITS-1:0]    in_tdata,
  // Result beats: [1:0] mode, [2] led_on, [3] pool_running, [7:4] hooks_to_run,
  // [8] drain_pending, [9] mandatory_abort, [10] cooperative_abort,
  // [11] flush_user_queue, [12] rejected, [15:13] zero.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [awc_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [awc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [awc_pkg::TIME_BITS-1:0]       cfg_data
);

  // Configuration registers.
  awc_pkg::time_t  ui_window_r, bg_window_r, grace_len_r, debounce_r;
  awc_pkg::hooks_t hook_count_r;
  logic            ui_mode_r;

  // Controller state.
  awc_pkg::mode_t  mode_r, mode_nxt;
  awc_pkg::time_t  window_r, window_nxt;
  awc_pkg::time_t  grace_r, grace_nxt;
  awc_pkg::time_t  settle_r, settle_nxt;

  // Result register.
  logic             out_valid_r;
  awc_pkg::result_t result_r, result_nxt;

  logic           in_fire;
  awc_pkg::op_t   op;
  logic           busy;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign op        = awc_pkg::op_t'(in_tdata[2:0]);
  assign busy      = in_tdata[3];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ui_window_r  <= awc_pkg::TIME_BITS'(10000);
      bg_window_r  <= awc_pkg::TIME_BITS'(5000);
      grace_len_r  <= awc_pkg::TIME_BITS'(2000);
      debounce_r   <= awc_pkg::TIME_BITS'(500);
      hook_count_r <= '0;
      ui_mode_r    <= 1'b1;
    end else if (cfg_valid) begin
      case (awc_pkg::cfg_idx_t'(cfg_index))
        awc_pkg::CFG_UI_WINDOW: ui_window_r  <= cfg_data;
        awc_pkg::CFG_BG_WINDOW: bg_window_r  <= cfg_data;
        awc_pkg::CFG_GRACE:     grace_len_r  <= cfg_data;
        awc_pkg::CFG_DEBOUNCE:  debounce_r   <= cfg_data;
        awc_pkg::CFG_HOOKS:     hook_count_r <= cfg_data[awc_pkg::HOOK_BITS-1:0];
        awc_pkg::CFG_UI_MODE:   ui_mode_r    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Event decode. The blocking assignments follow the order in which the handlers
  // act: a later handler sees what an earlier one has left.
  always_comb begin
    awc_pkg::mode_t  m;
    awc_pkg::time_t  wl, gl, sl, rem, deb;
    awc_pkg::hooks_t hooks_sat;
    logic            we, ge, se, curfew, active;
    logic            o_drain, o_mand, o_coop, o_flush, o_rej;
    awc_pkg::hooks_t o_hooks;

    m  = mode_r;
    wl = window_r;
    gl = grace_r;
    sl = settle_r;
    we = 1'b0;
    ge = 1'b0;
    se = 1'b0;
    curfew  = 1'b0;
    active  = 1'b0;
    rem     = '0;
    deb     = awc_pkg::load_len(debounce_r);
    o_drain = 1'b0;
    o_mand  = 1'b0;
    o_coop  = 1'b0;
    o_flush = 1'b0;
    o_rej   = 1'b0;
    o_hooks = '0;
    hooks_sat = (hook_count_r > awc_pkg::MAX_HOOKS) ? awc_pkg::MAX_HOOKS : hook_count_r;

    case (op)
      awc_pkg::OP_TICK: begin
        if (wl != '0) begin
          wl = wl - awc_pkg::TIME_BITS'(1);
          we = (wl == '0);
        end
        if (gl != '0) begin
          gl = gl - awc_pkg::TIME_BITS'(1);
          ge = (gl == '0);
        end
        if (sl != '0) begin
          sl = sl - awc_pkg::TIME_BITS'(1);
          se = (sl == '0);
        end
        active = (m == awc_pkg::MODE_UI) || (m == awc_pkg::MODE_BG);
        // Window end, or an idle settlement that ran out during an active window.
        if (we && active) begin
          curfew = 1'b1;
          se = 1'b0;
          ge = 1'b0;
        end else if (se && !busy && active) begin
          curfew = 1'b1;
          se = 1'b0;
        end
        if (curfew) begin
          wl = '0;
          sl = '0;
          if (hooks_sat == '0 && !busy) begin
            m  = awc_pkg::MODE_SLEEP;
            gl = '0;
            o_drain = 1'b1;
            o_mand  = 1'b1;
          end else begin
            m  = awc_pkg::MODE_GRACE;
            gl = awc_pkg::load_len(grace_len_r);
            o_hooks = hooks_sat;
          end
        end
        // Grace expiry ends in sleep with a cooperative abort and a queue flush; an idle
        // settlement during grace ends it early without them.
        if (ge && m == awc_pkg::MODE_GRACE) begin
          o_coop  = 1'b1;
          o_flush = 1'b1;
          o_drain = 1'b1;
          o_mand  = 1'b1;
          m  = awc_pkg::MODE_SLEEP;
          wl = '0;
          gl = '0;
          sl = '0;
        end else if (se && !busy && m == awc_pkg::MODE_GRACE) begin
          o_drain = 1'b1;
          o_mand  = 1'b1;
          m  = awc_pkg::MODE_SLEEP;
          wl = '0;
          gl = '0;
          sl = '0;
        end
      end
      awc_pkg::OP_START, awc_pkg::OP_IDLE: begin
        if (op == awc_pkg::OP_START) begin
          if (m != awc_pkg::MODE_SLEEP) begin
            o_rej = 1'b1;
          end else if (ui_mode_r) begin
            m  = awc_pkg::MODE_UI;
            wl = awc_pkg::load_len(ui_window_r);
          end else begin
            m  = awc_pkg::MODE_BG;
            wl = awc_pkg::load_len(bg_window_r);
          end
        end
        // Idle check, also run straight after a successful start.
        if (!o_rej && !busy && sl == '0) begin
          if (m == awc_pkg::MODE_UI || m == awc_pkg::MODE_BG) begin
            rem = wl;
          end else if (m == awc_pkg::MODE_GRACE) begin
            rem = gl;
          end else begin
            rem = '0;
          end
          if (rem != '0) begin
            sl = (rem < deb) ? rem : deb;
          end
        end
      end
      awc_pkg::OP_CANCEL: begin
        sl = '0;
      end
      awc_pkg::OP_SLEEP: begin
        if (m == awc_pkg::MODE_SLEEP) begin
          o_rej = 1'b1;
        end else begin
          m  = awc_pkg::MODE_SLEEP;
          wl = '0;
          gl = '0;
          sl = '0;
          o_drain = 1'b1;
          o_mand  = 1'b1;
        end
      end
      default: begin
        o_rej = 1'b1;
      end
    endcase

    mode_nxt   = m;
    window_nxt = wl;
    grace_nxt  = gl;
    settle_nxt = sl;

    result_nxt.pad               = '0;
    result_nxt.rejected          = o_rej;
    result_nxt.flush_user_queue  = o_flush;
    result_nxt.cooperative_abort = o_coop;
    result_nxt.mandatory_abort   = o_mand;
    result_nxt.drain_pending     = o_drain;
    result_nxt.hooks_to_run      = o_hooks;
    result_nxt.pool_running      = (m != awc_pkg::MODE_SLEEP);
    result_nxt.led_on            = (m != awc_pkg::MODE_SLEEP);
    result_nxt.mode              = m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= awc_pkg::MODE_SLEEP;
      window_r    <= '0;
      grace_r     <= '0;
      settle_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_r      <= mode_nxt;
        window_r    <= window_nxt;
        grace_r     <= grace_nxt;
        settle_r    <= settle_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

endmodule

// ===== hdl/awc_checker.sv =====
// Port-level checks of the activity window controller and their bind.
module awc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [awc_pkg::OUT_DATA_BITS-1:0] out_tdata
);

  // A stalled result beat must not change.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Hooks are only dispatched on entry to grace.
  a_hooks_grace: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7:4] != 4'd0 |-> out_tdata[1:0] == awc_pkg::MODE_GRACE)
    else $error("hooks dispatched outside grace");

  // Sleep entry drains and aborts together, and leaves the indicators off.
  a_sleep_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> out_tdata[9] && out_tdata[1:0] == awc_pkg::MODE_SLEEP
      && !out_tdata[2] && !out_tdata[3])
    else $error("inconsistent sleep entry");

  // Grace expiry always comes with a flush and a sleep entry.
  a_grace_expiry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10] |-> out_tdata[11] && out_tdata[8]
      && out_tdata[7:4] == 4'd0 && !out_tdata[12])
    else $error("grace expiry without flush or sleep entry");

endmodule

bind activity_window_controller awc_checker u_awc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
